[rtl/srbs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srbs_pkg
// Shared types and constants of the sorted range bound search core.
// ----------------------------------------------------------------------------
package srbs_pkg;

   localparam int VALUE_W    = 64;
   localparam int POS_W      = 10;
   localparam int REQ_DATA_W = 128;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 24;

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // last field in the lowest bits
   typedef struct packed {
      logic [1:0]       pad;
      logic             overflowed;
      logic [POS_W-1:0] last_position;
      logic [POS_W-1:0] first_position;
      logic             found;
   } rsp_type;

endpackage
`default_nettype wire

[rtl/srbs_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srbs_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module srbs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [WIDTH-1:0]  wdata,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

[rtl/sorted_range_bound_search_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_range_bound_search_core
// Keeps an ascending list of signed 64-bit values and returns the first and
// last index holding a key, found by two binary searches.
// ----------------------------------------------------------------------------
// An append item writes one value to the end of the list and gives no
// result; start_list on an append restarts the list, and appends to a full
// store are dropped and flagged through overflowed. A search item runs two
// binary searches, one after the other, over the single-port value store:
// each pass has a setup state and then one probe per store read, at most
// clog2(DEPTH)+1 probes, and the result item is offered on the result side
// once both passes are done. The store gives one memory read per cycle, so
// the probes run in sequence and no new request is taken during a search.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sorted_range_bound_search_core #(
   parameter int DEPTH = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // element_value [63:0], search_key [127:64]
   input  wire logic [127:0] req_tdata,
   // opcode [0], start_list [1]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // found [0], first_position [10:1], last_position [20:11], overflowed [21]
   output logic [23:0]      rsp_tdata
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = $clog2(DEPTH + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_START = 2'd1;
   localparam logic [1:0] S_PROBE = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [LW-1:0] len_ff, len_in;
   logic          ovf_ff, ovf_in;
   logic [LW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [AW-1:0] mid_ff, mid_in;
   logic          pass_ff, pass_in;
   logic          hit_ff, hit_in;
   logic [AW-1:0] where_ff, where_in;
   logic          first_hit_ff, first_hit_in;
   logic [AW-1:0] first_pos_ff, first_pos_in;
   logic signed [srbs_pkg::VALUE_W-1:0] key_ff, key_in;
   logic          rsp_valid_ff, rsp_valid_in;
   srbs_pkg::rsp_type rsp_ff, rsp_in;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [srbs_pkg::VALUE_W-1:0] ram_wdata, ram_rdata;

   logic          req_acc;
   logic          req_op, req_start;
   logic [srbs_pkg::VALUE_W-1:0] req_elem, req_key;
   logic [LW-1:0] app_len;
   logic          cmp_eq, cmp_lt;
   logic [LW-1:0] plo, phi, nmid;
   logic          phit;
   logic [AW-1:0] pwhere;
   logic          found;

   assign req_op    = req_tuser[0];
   assign req_start = req_tuser[1];
   assign req_elem  = req_tdata[63:0];
   assign req_key   = req_tdata[127:64];
   assign req_tready = (state_ff == S_IDLE);
   assign req_acc   = req_tvalid && req_tready;

   assign cmp_eq = ($signed(ram_rdata) == key_ff);
   assign cmp_lt = ($signed(ram_rdata) < key_ff);
   assign found  = first_hit_ff && hit_ff;

   srbs_ram #(
      .WIDTH(srbs_pkg::VALUE_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   // narrowing of the search range after a probe
   always_comb begin
      plo    = lo_ff;
      phi    = hi_ff;
      phit   = hit_ff;
      pwhere = where_ff;
      if (state_ff == S_PROBE) begin
         if (cmp_eq) begin
            phit   = 1'b1;
            pwhere = mid_ff;
            if (pass_ff) begin
               plo = LW'(mid_ff) + LW'(1);
            end else begin
               phi = LW'(mid_ff);
            end
         end else if (cmp_lt) begin
            plo = LW'(mid_ff) + LW'(1);
         end else begin
            phi = LW'(mid_ff);
         end
      end
      nmid = plo + ((phi - plo - LW'(1)) >> 1);
   end

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      pass_in      = pass_ff;
      hit_in       = hit_ff;
      where_in     = where_ff;
      first_hit_in = first_hit_ff;
      first_pos_in = first_pos_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_wdata    = req_elem;
      app_len      = req_start ? '0 : len_ff;
      ram_addr     = app_len[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_op == srbs_pkg::OP_APPEND) begin
                  if (req_start) begin
                     ovf_in = 1'b0;
                  end
                  if (app_len < LW'(DEPTH)) begin
                     ram_we = 1'b1;
                     len_in = app_len + LW'(1);
                  end else begin
                     len_in = app_len;
                     ovf_in = 1'b1;
                  end
               end else begin
                  key_in   = req_key;
                  lo_in    = '0;
                  hi_in    = len_ff;
                  pass_in  = 1'b0;
                  hit_in   = 1'b0;
                  where_in = '0;
                  state_in = S_START;
               end
            end
         end
         S_START, S_PROBE: begin
            hit_in   = phit;
            where_in = pwhere;
            if (plo < phi) begin
               ram_addr = nmid[AW-1:0];
               mid_in   = nmid[AW-1:0];
               lo_in    = plo;
               hi_in    = phi;
               state_in = S_PROBE;
            end else if (!pass_ff) begin
               first_hit_in = phit;
               first_pos_in = pwhere;
               pass_in      = 1'b1;
               lo_in        = '0;
               hi_in        = len_ff;
               hit_in       = 1'b0;
               where_in     = '0;
               state_in     = S_START;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in          = 1'b1;
               rsp_in.pad            = '0;
               rsp_in.found          = found;
               rsp_in.first_position = found ? srbs_pkg::POS_W'(first_pos_ff) : '0;
               rsp_in.last_position  = found ? srbs_pkg::POS_W'(where_ff) : '0;
               rsp_in.overflowed     = ovf_ff;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      pass_ff      <= pass_in;
      hit_ff       <= hit_in;
      where_ff     <= where_in;
      first_hit_ff <= first_hit_in;
      first_pos_ff <= first_pos_in;
      key_ff       <= key_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

`ifndef ASSERT_OFF
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(DEPTH))
      else $error("list length beyond depth");

   a_mid_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PROBE |-> (LW'(mid_ff) >= lo_ff) && (LW'(mid_ff) < hi_ff))
      else $error("probe outside search range");

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == S_IDLE)
      else $error("store write during search");

   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.found |->
         rsp_ff.first_position == '0 && rsp_ff.last_position == '0)
      else $error("nonzero position on absent key");
`endif

endmodule
`default_nettype wire
